// ===== rtl/ack_retry_sender_assert.svh =====
// Assertion macros for the stop-and-wait sender core module.
`ifndef ACK_RETRY_SENDER_ASSERT_SVH
`define ACK_RETRY_SENDER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define ARSND_AST_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ack_retry_sender: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define ARSND_AST_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ack_retry_sender: next-cycle check failed");

`endif

// ===== rtl/arsnd_pkg.sv =====
// Types and codes shared by the stop-and-wait sender modules.
package arsnd_pkg;

  // Event codes on the request channel
  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_STATUS = 2'd1,
    ACT_ACK    = 2'd2,
    ACT_TICK   = 2'd3
  } action_t;

  // Result kinds
  typedef enum logic {
    RES_SEND   = 1'b0,
    RES_FINISH = 1'b1
  } res_kind_t;

  // Finish outcomes
  typedef enum logic [1:0] {
    OUT_ACCEPTED  = 2'd0,
    OUT_REJECTED  = 2'd1,
    OUT_EXHAUSTED = 2'd2
  } outcome_t;

  // Configuration register indexes
  typedef enum logic [7:0] {
    CFG_MAX_ATTEMPTS = 8'd0,
    CFG_ACK_TIMEOUT  = 8'd1,
    CFG_OWN_DEVICE   = 8'd2,
    CFG_ACK_TYPE     = 8'd3
  } cfg_idx_t;

  localparam int unsigned CfgDataW = 16;

  // Configuration register reset values
  localparam logic [7:0]  MaxAttemptsRst = 8'd3;
  localparam logic [15:0] AckTimeoutRst  = 16'd100;
  localparam logic [7:0]  OwnDeviceRst   = 8'd0;
  localparam logic [7:0]  AckTypeRst     = 8'd1;

  typedef struct packed {
    logic [7:0]  max_attempts;
    logic [15:0] ack_timeout_ticks;
    logic [7:0]  own_device;
    logic [7:0]  ack_type_code;
  } cfg_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] seq_counter;
    logic        send_ok;
    logic        length_ok;
    logic [7:0]  packet_kind;
    logic [7:0]  sender_device;
    logic        ack_accepted;
  } item_t;

  typedef struct packed {
    logic        valid;
    res_kind_t   kind;
    logic [31:0] frame_counter;
    logic [7:0]  attempt_number;
    outcome_t    outcome;
  } res_t;

endpackage

// ===== rtl/arsnd_cfg.sv =====
// Configuration register file of the stop-and-wait sender.
module arsnd_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [7:0]                        wr_index,
  input  logic [arsnd_pkg::CfgDataW-1:0]    wr_data,
  output arsnd_pkg::cfg_t                   cfg
);
  import arsnd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write index; unknown indexes leave the registers alone
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_MAX_ATTEMPTS: cfg_nxt.max_attempts      = wr_data[7:0];
        CFG_ACK_TIMEOUT:  cfg_nxt.ack_timeout_ticks = wr_data[15:0];
        CFG_OWN_DEVICE:   cfg_nxt.own_device        = wr_data[7:0];
        CFG_ACK_TYPE:     cfg_nxt.ack_type_code     = wr_data[7:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_attempts      <= MaxAttemptsRst;
      cfg_r.ack_timeout_ticks <= AckTimeoutRst;
      cfg_r.own_device        <= OwnDeviceRst;
      cfg_r.ack_type_code     <= AckTypeRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/arsnd_core.sv =====
// Transfer state and per-event decision logic of the stop-and-wait sender.
module arsnd_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             ev_valid,
  input  arsnd_pkg::item_t item,
  input  arsnd_pkg::cfg_t  cfg,
  output arsnd_pkg::res_t  res
);
  import arsnd_pkg::*;

  logic        busy_r, busy_nxt;
  logic        awaiting_r, awaiting_nxt;
  logic [31:0] pending_r, pending_nxt;
  logic [7:0]  attempt_r, attempt_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;

  logic [8:0]  next_attempt;
  logic        exhaust;
  logic        retry;
  logic        ack_match;
  logic [15:0] elapsed_inc;

  assign next_attempt = {1'b0, attempt_r} + 9'd1;
  assign exhaust      = next_attempt >= {1'b0, cfg.max_attempts};
  assign elapsed_inc  = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;
  assign ack_match    = item.length_ok && (item.packet_kind == cfg.ack_type_code) &&
                        (item.sender_device == cfg.own_device) &&
                        (item.seq_counter == pending_r);

  // Work out the next state and the result of the event
  always_comb begin
    busy_nxt     = busy_r;
    awaiting_nxt = awaiting_r;
    pending_nxt  = pending_r;
    attempt_nxt  = attempt_r;
    elapsed_nxt  = elapsed_r;
    retry        = 1'b0;
    res          = '0;

    if (ev_valid) begin
      unique case (item.action)
        ACT_START: begin
          if (!busy_r) begin
            pending_nxt       = item.seq_counter;
            attempt_nxt       = 8'd0;
            awaiting_nxt      = 1'b0;
            elapsed_nxt       = 16'd0;
            res.valid         = 1'b1;
            res.frame_counter = item.seq_counter;
            if (cfg.max_attempts == 8'd0) begin
              res.kind    = RES_FINISH;
              res.outcome = OUT_EXHAUSTED;
            end else begin
              busy_nxt = 1'b1;
              res.kind = RES_SEND;
            end
          end
        end
        ACT_STATUS: begin
          if (busy_r && !awaiting_r) begin
            if (item.send_ok) begin
              awaiting_nxt = 1'b1;
              elapsed_nxt  = 16'd0;
            end else begin
              retry = 1'b1;
            end
          end
        end
        ACT_ACK: begin
          if (awaiting_r && ack_match) begin
            awaiting_nxt       = 1'b0;
            busy_nxt           = 1'b0;
            elapsed_nxt        = 16'd0;
            res.valid          = 1'b1;
            res.kind           = RES_FINISH;
            res.frame_counter  = pending_r;
            res.attempt_number = attempt_r;
            res.outcome        = item.ack_accepted ? OUT_ACCEPTED : OUT_REJECTED;
          end
        end
        ACT_TICK: begin
          if (awaiting_r) begin
            elapsed_nxt = elapsed_inc;
            if (elapsed_inc >= cfg.ack_timeout_ticks) retry = 1'b1;
          end
        end
        default: begin
          res = '0;
        end
      endcase
    end

    // Advance to the next attempt or give up
    if (retry) begin
      awaiting_nxt      = 1'b0;
      elapsed_nxt       = 16'd0;
      res.valid         = 1'b1;
      res.frame_counter = pending_r;
      if (exhaust) begin
        busy_nxt           = 1'b0;
        res.kind           = RES_FINISH;
        res.attempt_number = attempt_r;
        res.outcome        = OUT_EXHAUSTED;
      end else begin
        attempt_nxt        = next_attempt[7:0];
        res.kind           = RES_SEND;
        res.attempt_number = next_attempt[7:0];
        res.outcome        = OUT_ACCEPTED;
      end
    end
  end

  // Hold the transfer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      awaiting_r <= 1'b0;
      pending_r  <= '0;
      attempt_r  <= '0;
      elapsed_r  <= '0;
    end else begin
      busy_r     <= busy_nxt;
      awaiting_r <= awaiting_nxt;
      pending_r  <= pending_nxt;
      attempt_r  <= attempt_nxt;
      elapsed_r  <= elapsed_nxt;
    end
  end

`include "ack_retry_sender_assert.svh"

  `ARSND_AST_SAME(a_wait_needs_busy, awaiting_r, busy_r)
  `ARSND_AST_SAME(a_ticks_only_waiting, elapsed_r != 16'd0, awaiting_r)
  `ARSND_AST_NEXT(a_finish_frees, res.valid && (res.kind == RES_FINISH), !busy_r && !awaiting_r)

endmodule

// ===== rtl/ack_retry_sender.sv =====
// Top level of the stop-and-wait sender: request, result and register ports.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready   | action, counter, status and ack fields
//   out_    | output    | out_valid / out_ready | result kind, counter, attempt, outcome
//   cfg_    | input     | cfg_valid / cfg_ready | register index, write data
//
// While out_ready is high, one request per cycle is sustained; a request passes an
// input register, the decision logic and a result register, and its result shows on
// out_valid once it enters the result register. A request leaves the input register
// only when the result register is free or being emptied, so while a result waits
// with out_ready low and the input register full, in_ready is low in that same cycle.
// Synchronous active-low reset clears all control state; cfg_ready is always high.
module ack_retry_sender (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_action,
  input  logic [31:0]                    in_seq_counter,
  input  logic                           in_send_ok,
  input  logic                           in_length_ok,
  input  logic [7:0]                     in_packet_kind,
  input  logic [7:0]                     in_sender_device,
  input  logic                           in_ack_accepted,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_result_kind,
  output logic [31:0]                    out_frame_counter,
  output logic [7:0]                     out_attempt_number,
  output logic [1:0]                     out_outcome,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [7:0]                     cfg_index,
  input  logic [arsnd_pkg::CfgDataW-1:0] cfg_data
);
  import arsnd_pkg::*;

  cfg_t  cfg;
  item_t item_r, item_nxt;
  logic  inq_valid_r, inq_valid_nxt;
  res_t  res;
  res_t  out_r, out_nxt;
  logic  adv;

  assign cfg_ready = 1'b1;

  arsnd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Advance a request when the result register can take its outcome
  assign adv      = inq_valid_r && (!out_r.valid || out_ready);
  assign in_ready = !inq_valid_r || adv;

  // Capture an incoming request
  always_comb begin
    item_nxt      = item_r;
    inq_valid_nxt = inq_valid_r && !adv;
    if (in_valid && in_ready) begin
      item_nxt.action        = action_t'(in_action);
      item_nxt.seq_counter   = in_seq_counter;
      item_nxt.send_ok       = in_send_ok;
      item_nxt.length_ok     = in_length_ok;
      item_nxt.packet_kind   = in_packet_kind;
      item_nxt.sender_device = in_sender_device;
      item_nxt.ack_accepted  = in_ack_accepted;
      inq_valid_nxt          = 1'b1;
    end
  end

  arsnd_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .ev_valid (adv),
    .item     (item_r),
    .cfg      (cfg),
    .res      (res)
  );

  // Load or drain the result register
  always_comb begin
    out_nxt = out_r;
    if (adv) begin
      out_nxt = res;
    end else if (out_ready) begin
      out_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
      out_r       <= '0;
    end else begin
      inq_valid_r <= inq_valid_nxt;
      out_r       <= out_nxt;
    end
  end

  // Request payload register needs no reset
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign out_valid          = out_r.valid;
  assign out_result_kind    = out_r.kind;
  assign out_frame_counter  = out_r.frame_counter;
  assign out_attempt_number = out_r.attempt_number;
  assign out_outcome        = out_r.outcome;

endmodule
